FILE: rtl/u8d_pkg.sv
// u8d_pkg: shared types and constants of the UTF-8 stream decoder.
// Holds the decoder state and result records and the lead-byte length function.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package u8d_pkg;

    localparam int unsigned IN_TDATA_W  = 8;
    localparam int unsigned OUT_TDATA_W = 40;
    localparam int unsigned CODE_W      = 32;
    localparam int unsigned ACCUM_W     = 21;

    localparam logic [CODE_W-1:0] INVALID_CODE_RESET = 32'd65533;

    localparam logic [2:0] LEN_NONE     = 3'd0;
    localparam logic [3:0] LEN_MIN_LEAD = 4'd2;
    localparam logic [3:0] LEN_MAX_LEAD = 4'd7;
    localparam logic [3:0] LEN_MAX_GOOD = 4'd4;

    typedef struct packed {
        logic [2:0]         seq_length;
        logic [2:0]         bytes_taken;
        logic [ACCUM_W-1:0] code_accum;
        logic               seq_bad;
    } dec_state_t;

    typedef struct packed {
        logic [CODE_W-1:0] code_point;
        logic              is_invalid;
        logic [2:0]        bytes_used;
        logic              buffer_end;
    } result_t;

    function automatic logic [3:0] lead_ones(input logic [7:0] b);
        logic [3:0] n;
        unique casez (b)
            8'b0???????: n = 4'd0;
            8'b10??????: n = 4'd1;
            8'b110?????: n = 4'd2;
            8'b1110????: n = 4'd3;
            8'b11110???: n = 4'd4;
            8'b111110??: n = 4'd5;
            8'b1111110?: n = 4'd6;
            8'b11111110: n = 4'd7;
            default:     n = 4'd8;
        endcase
        return n;
    endfunction

endpackage

`default_nettype wire

FILE: rtl/u8d_step.sv
// u8d_step: next-state and result logic for one input byte.
// Depends on u8d_pkg for the state and result records.
`timescale 1ns / 1ps
`default_nettype none

module u8d_step (
    input  wire logic [7:0]                   byte_value,
    input  wire logic                         last_byte,
    input  wire logic [u8d_pkg::CODE_W-1:0]   invalid_code,
    input  wire u8d_pkg::dec_state_t          state,
    output u8d_pkg::dec_state_t               state_next,
    output logic                              emit,
    output u8d_pkg::result_t                  result
);

    logic [3:0]                    len;
    logic [7:0]                    lead_bits;
    logic [2:0]                    taken_inc;
    logic                          cont_ok;
    logic                          bad_inc;
    logic [u8d_pkg::ACCUM_W-1:0]   accum_inc;
    logic                          bad_out;
    logic [u8d_pkg::ACCUM_W-1:0]   cp_out;

    assign len       = u8d_pkg::lead_ones(byte_value);
    assign lead_bits = byte_value & (8'h7F >> len);
    assign taken_inc = state.bytes_taken + 3'd1;
    assign cont_ok   = (byte_value[7:6] == 2'b10);
    assign bad_inc   = state.seq_bad | ~cont_ok;
    assign accum_inc = bad_inc ? state.code_accum
                               : {state.code_accum[u8d_pkg::ACCUM_W-7:0], byte_value[5:0]};

    always_comb begin
        state_next = state;
        emit       = 1'b0;
        bad_out    = 1'b0;
        cp_out     = '0;
        result.bytes_used = 3'd1;
        result.buffer_end = last_byte;
        if (state.seq_length == u8d_pkg::LEN_NONE) begin
            if (!byte_value[7]) begin
                emit   = 1'b1;
                cp_out = {13'd0, byte_value};
            end else if (len < u8d_pkg::LEN_MIN_LEAD || len > u8d_pkg::LEN_MAX_LEAD
                         || last_byte) begin
                emit    = 1'b1;
                bad_out = 1'b1;
            end else begin
                state_next.seq_length  = len[2:0];
                state_next.bytes_taken = 3'd1;
                state_next.seq_bad     = (len > u8d_pkg::LEN_MAX_GOOD);
                state_next.code_accum  = (len > u8d_pkg::LEN_MAX_GOOD) ? '0
                                                                       : {13'd0, lead_bits};
            end
        end else begin
            if (taken_inc == state.seq_length) begin
                emit              = 1'b1;
                bad_out           = bad_inc;
                cp_out            = accum_inc;
                result.bytes_used = taken_inc;
                state_next        = '0;
            end else if (last_byte) begin
                emit              = 1'b1;
                bad_out           = 1'b1;
                result.bytes_used = taken_inc;
                state_next        = '0;
            end else begin
                state_next.bytes_taken = taken_inc;
                state_next.seq_bad     = bad_inc;
                state_next.code_accum  = accum_inc;
            end
        end
        result.is_invalid = bad_out;
        result.code_point = bad_out ? invalid_code : {11'd0, cp_out};
    end

endmodule

`default_nettype wire

FILE: rtl/u8d_out_buf.sv
// u8d_out_buf: output register with a skid stage for decoded results.
// Depends on u8d_pkg for the result record.
`timescale 1ns / 1ps
`default_nettype none

module u8d_out_buf (
    input  wire logic         aclk,
    input  wire logic         aresetn,
    input  wire logic         push,
    input  wire u8d_pkg::result_t push_data,
    output logic              space,
    output logic              out_valid,
    input  wire logic         out_ready,
    output u8d_pkg::result_t  out_data
);

    logic             out_valid_reg;
    logic             skid_valid_reg;
    u8d_pkg::result_t out_data_reg;
    u8d_pkg::result_t skid_data_reg;
    logic             pop;

    assign pop       = out_valid_reg & out_ready;
    assign space     = ~skid_valid_reg;
    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end else if (skid_valid_reg) begin
            if (pop) begin
                skid_valid_reg <= 1'b0;
            end
        end else if (push) begin
            if (!out_valid_reg || pop) begin
                out_valid_reg <= 1'b1;
            end else begin
                skid_valid_reg <= 1'b1;
            end
        end else if (pop) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (skid_valid_reg) begin
            if (pop) begin
                out_data_reg <= skid_data_reg;
            end
        end else if (push) begin
            if (!out_valid_reg || pop) begin
                out_data_reg <= push_data;
            end else begin
                skid_data_reg <= push_data;
            end
        end
    end

endmodule

`default_nettype wire

FILE: rtl/utf8_stream_decoder.sv
// utf8_stream_decoder: streaming UTF-8 decoder, one byte per beat.
// Depends on u8d_pkg, u8d_step and u8d_out_buf.
//
// Usage:
//   s_ channel: one raw byte per beat in s_tdata, s_tlast on the buffer's last byte.
//   m_ channel: one beat per completed character: code point and bytes used in
//   m_tdata, invalid flag in m_tuser, m_tlast when the last byte caused it.
//   cfg channel: writes the code point reported for invalid sequences; always
//   ready, write only while no beat is in flight.
// Throughput: one byte per cycle while s_tready is high. The sequence state updates in the same cycle
// the byte is taken, so the next byte follows without a gap.
// A result is registered in the output register, or the skid stage while that one is stalled.
// Stall: the output register holds one result and a one-beat skid stage a second
// while m_tready is low; s_tready drops only once the skid stage is full.
// Reset: clears the open sequence and both output stages and sets the invalid
// code to 0xFFFD.
`timescale 1ns / 1ps
`default_nettype none

module utf8_stream_decoder (
    input  wire logic                                 aclk,
    input  wire logic                                 aresetn,
    input  wire logic                                 s_tvalid,
    output logic                                      s_tready,
    input  wire logic [u8d_pkg::IN_TDATA_W-1:0]       s_tdata,   // [7:0] byte_value
    input  wire logic                                 s_tlast,   // last_byte
    output logic                                      m_tvalid,
    input  wire logic                                 m_tready,
    output logic [u8d_pkg::OUT_TDATA_W-1:0]           m_tdata,   // [31:0] code_point,
                                                                 // [34:32] bytes_used, zero pad
    output logic                                      m_tuser,   // is_invalid
    output logic                                      m_tlast,   // buffer_end
    input  wire logic                                 cfg_valid,
    output logic                                      cfg_ready,
    input  wire logic [u8d_pkg::CODE_W-1:0]           cfg_data   // invalid_code
);

    logic [u8d_pkg::CODE_W-1:0] invalid_code_reg;
    u8d_pkg::dec_state_t        state_reg;
    u8d_pkg::dec_state_t        state_next;
    u8d_pkg::result_t           step_result;
    u8d_pkg::result_t           out_result;
    logic                       step_emit;
    logic                       accept;

    assign cfg_ready = 1'b1;
    assign accept    = s_tvalid & s_tready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            invalid_code_reg <= u8d_pkg::INVALID_CODE_RESET;
        end else if (cfg_valid && cfg_ready) begin
            invalid_code_reg <= cfg_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= '0;
        end else if (accept) begin
            state_reg <= state_next;
        end
    end

    u8d_step u_step (
        .byte_value   (s_tdata),
        .last_byte    (s_tlast),
        .invalid_code (invalid_code_reg),
        .state        (state_reg),
        .state_next   (state_next),
        .emit         (step_emit),
        .result       (step_result)
    );

    u8d_out_buf u_out_buf (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (accept & step_emit),
        .push_data (step_result),
        .space     (s_tready),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .out_data  (out_result)
    );

    assign m_tdata = {5'd0, out_result.bytes_used, out_result.code_point};
    assign m_tuser = out_result.is_invalid;
    assign m_tlast = out_result.buffer_end;

    a_skid_implies_out : assert property (@(posedge aclk) disable iff (!aresetn)
        !s_tready |-> m_tvalid)
        else $error("skid stage full while output register empty");

    a_used_nonzero : assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> m_tdata[34:32] != 3'd0)
        else $error("result with zero bytes used");

    a_single_valid_ascii : assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && !m_tuser && m_tdata[34:32] == 3'd1) |-> m_tdata[31:7] == 25'd0)
        else $error("valid one-byte result outside ASCII range");

    a_last_closes : assert property (@(posedge aclk) disable iff (!aresetn)
        (s_tvalid && s_tready && s_tlast) |=> state_reg.seq_length == u8d_pkg::LEN_NONE)
        else $error("sequence left open after last byte");

endmodule

`default_nettype wire

FILE: bench/tb_utf8_stream_decoder.sv
// tb_utf8_stream_decoder: self-checking bench for the UTF-8 stream decoder.
// A directed byte table, then random buffers of mostly well-formed characters, checked
// beat by beat against a behavioral decoder. Depends on u8d_pkg and utf8_stream_decoder.
`timescale 1ns / 1ps

module tb_utf8_stream_decoder;

    typedef struct {
        logic [7:0] value;
        logic       last;
    } stream_byte_t;

    typedef struct {
        logic [7:0]       value;
        logic             last;
        bit               has_want;
        u8d_pkg::result_t want;
    } stim_row_t;

    localparam int PHASES      = 5;
    localparam int PHASE_BYTES = 390;
    localparam int HOLD_CYCLES = 300;

    logic                            aclk = 1'b0;
    logic                            aresetn = 1'b0;
    logic                            s_tvalid = 1'b0;
    logic                            s_tready;
    logic [u8d_pkg::IN_TDATA_W-1:0]  s_tdata = '0;       // [7:0] byte_value
    logic                            s_tlast = 1'b0;     // last_byte
    logic                            m_tvalid;
    logic                            m_tready = 1'b0;
    logic [u8d_pkg::OUT_TDATA_W-1:0] m_tdata;            // [31:0] code_point, [34:32] bytes_used
    logic                            m_tuser;            // is_invalid
    logic                            m_tlast;            // buffer_end
    logic                            cfg_valid = 1'b0;
    logic                            cfg_ready;
    logic [u8d_pkg::CODE_W-1:0]      cfg_data = '0;      // invalid_code

    // decoder state mirrored by the bench
    logic [2:0]                  open_len = u8d_pkg::LEN_NONE;
    logic [2:0]                  taken = '0;
    logic [u8d_pkg::ACCUM_W-1:0] partial = '0;
    logic                        broken = 1'b0;
    logic [u8d_pkg::CODE_W-1:0]  invalid_cp = u8d_pkg::INVALID_CODE_RESET;

    u8d_pkg::result_t chars_due [$];
    stream_byte_t     byte_plan [$];
    int               errors = 0;
    bit               calm = 1'b0;
    bit               hold_request = 1'b0;
    bit               hold_served = 1'b0;
    int               hold_left = 0;

    stim_row_t directed_rows [0:22] = '{
        '{8'h00, 1'b0, 1'b1, '{32'h0000_0000, 1'b0, 3'd1, 1'b0}},
        '{8'h7F, 1'b1, 1'b1, '{32'h0000_007F, 1'b0, 3'd1, 1'b1}},
        '{8'h80, 1'b0, 1'b1, '{u8d_pkg::INVALID_CODE_RESET, 1'b1, 3'd1, 1'b0}},
        '{8'hFF, 1'b0, 1'b1, '{u8d_pkg::INVALID_CODE_RESET, 1'b1, 3'd1, 1'b0}},
        '{8'hC2, 1'b0, 1'b0, '0},
        '{8'hA9, 1'b0, 1'b0, '0},
        '{8'hE2, 1'b0, 1'b0, '0},
        '{8'h82, 1'b0, 1'b0, '0},
        '{8'hAC, 1'b0, 1'b0, '0},
        '{8'hF0, 1'b0, 1'b0, '0},
        '{8'h9F, 1'b0, 1'b0, '0},
        '{8'h98, 1'b0, 1'b0, '0},
        '{8'h80, 1'b0, 1'b0, '0},
        '{8'hF8, 1'b0, 1'b0, '0},
        '{8'h80, 1'b0, 1'b0, '0},
        '{8'h00, 1'b0, 1'b0, '0},
        '{8'hFF, 1'b0, 1'b0, '0},
        '{8'hBF, 1'b0, 1'b1, '{u8d_pkg::INVALID_CODE_RESET, 1'b1, 3'd5, 1'b0}},
        '{8'hC3, 1'b0, 1'b0, '0},
        '{8'h41, 1'b0, 1'b1, '{u8d_pkg::INVALID_CODE_RESET, 1'b1, 3'd2, 1'b0}},
        '{8'hE2, 1'b0, 1'b0, '0},
        '{8'h82, 1'b1, 1'b1, '{u8d_pkg::INVALID_CODE_RESET, 1'b1, 3'd2, 1'b1}},
        '{8'hC3, 1'b1, 1'b1, '{u8d_pkg::INVALID_CODE_RESET, 1'b1, 3'd1, 1'b1}}
    };

    utf8_stream_decoder u_dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tlast   (s_tlast),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .m_tlast   (m_tlast),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data)
    );

    always begin
        #6 aclk = 1'b1;
        #6 aclk = 1'b0;
    end

    task automatic flag_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
        $display("%0t ns: mismatch on %s: got %0h, want %0h", $time, what, got, want);
        errors++;
    endtask

    task automatic close_sequence();
        open_len = u8d_pkg::LEN_NONE;
        taken    = '0;
        partial  = '0;
        broken   = 1'b0;
    endtask

    task automatic decode_byte(input logic [7:0] b, input logic last,
                               output bit hit, output u8d_pkg::result_t r);
        int n;
        hit = 1'b1;
        r = '0;
        r.buffer_end = last;
        if (open_len == u8d_pkg::LEN_NONE) begin
            n = 0;
            while (n < 8 && b[7 - n]) n++;
            r.bytes_used = 3'd1;
            if (n == 0) begin
                r.code_point = {24'd0, b};
            end else if (n < u8d_pkg::LEN_MIN_LEAD || n > u8d_pkg::LEN_MAX_LEAD || last) begin
                r.is_invalid = 1'b1;
            end else begin
                hit      = 1'b0;
                open_len = n[2:0];
                taken    = 3'd1;
                broken   = (n > u8d_pkg::LEN_MAX_GOOD);
                partial  = broken ? '0 : {13'd0, b & (8'h7F >> n)};
            end
        end else begin
            taken = taken + 3'd1;
            if (!broken) begin
                if (b[7:6] != 2'b10) broken = 1'b1;
                else partial = {partial[u8d_pkg::ACCUM_W-7:0], b[5:0]};
            end
            if (taken == open_len) begin
                r.is_invalid = broken;
                r.code_point = {11'd0, partial};
                r.bytes_used = taken;
                close_sequence();
            end else if (last) begin
                r.is_invalid = 1'b1;
                r.bytes_used = taken;
                close_sequence();
            end else begin
                hit = 1'b0;
            end
        end
        if (hit && r.is_invalid) r.code_point = invalid_cp;
    endtask

    task automatic offer_byte(input logic [7:0] b, input logic last,
                              input bit has_want, input u8d_pkg::result_t want);
        bit               hit;
        u8d_pkg::result_t r;
        while (!calm && $urandom_range(0, 99) < 23) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= b;
        s_tlast  <= last;
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        decode_byte(b, last, hit, r);
        if (has_want) r = want;
        if (hit || has_want) chars_due = {chars_due, r};
    endtask

    task automatic write_invalid_code(input logic [31:0] v);
        cfg_valid <= 1'b1;
        cfg_data  <= v;
        @(posedge aclk);
        while (!cfg_ready) @(posedge aclk);
        cfg_valid  <= 1'b0;
        invalid_cp = v;
    endtask

    // one character, sometimes broken, sometimes closing or cutting the buffer
    task automatic plan_character();
        logic [7:0]   seq [$];
        stream_byte_t sb;
        int           kind, n, k, cut;
        logic [7:0]   x;
        kind = $urandom_range(0, 99);
        if (kind < 25) begin
            x = {1'b0, 7'($urandom)};
            seq = {seq, x};
        end else if (kind < 75) begin
            n = $urandom_range(2, 4);
            x = (8'hFF << (8 - n)) | (8'($urandom) & (8'h7F >> n));
            seq = {seq, x};
            for (k = 1; k < n; k++) begin
                x = {2'b10, 6'($urandom)};
                seq = {seq, x};
            end
            if (kind >= 65) begin
                k = $urandom_range(1, n - 1);
                x = 8'($urandom);
                while (x[7:6] == 2'b10) x = 8'($urandom);
                seq[k] = x;
                for (k = k + 1; k < n; k++) seq[k] = 8'($urandom);
            end
        end else if (kind < 83) begin
            n = $urandom_range(5, 7);
            x = (8'hFF << (8 - n)) | (8'($urandom) & (8'h7F >> n));
            seq = {seq, x};
            for (k = 1; k < n; k++) begin
                x = 8'($urandom);
                seq = {seq, x};
            end
        end else if (kind < 90) begin
            x = $urandom_range(0, 1) ? 8'hFF : {2'b10, 6'($urandom)};
            seq = {seq, x};
        end else begin
            x = 8'($urandom);
            seq = {seq, x};
        end
        cut = seq.size();
        if (seq.size() > 1 && $urandom_range(0, 99) < 6) cut = $urandom_range(1, seq.size() - 1);
        for (k = 0; k < cut; k++) begin
            sb.value = seq[k];
            sb.last  = 1'b0;
            byte_plan = {byte_plan, sb};
        end
        if (cut < seq.size() || $urandom_range(0, 99) < 8)
            byte_plan[byte_plan.size() - 1].last = 1'b1;
    endtask

    always @(posedge aclk) begin
        if (hold_left != 0) begin
            m_tready  <= 1'b0;
            hold_left <= hold_left - 1;
        end else if (hold_request && !hold_served) begin
            m_tready    <= 1'b0;
            hold_left   <= HOLD_CYCLES;
            hold_served <= 1'b1;
        end else begin
            m_tready <= calm || $urandom_range(0, 99) >= 23;
        end
    end

    always @(posedge aclk) begin : check_beat
        u8d_pkg::result_t want;
        if (aresetn && m_tvalid && m_tready) begin
            if (chars_due.size() == 0) begin
                flag_mismatch("unexpected beat code_point", m_tdata[31:0], '0);
            end else begin
                want = chars_due.pop_front();
                if (m_tdata[31:0] != want.code_point)
                    flag_mismatch("code_point", m_tdata[31:0], want.code_point);
                if (m_tuser != want.is_invalid)
                    flag_mismatch("is_invalid", 32'(m_tuser), 32'(want.is_invalid));
                if (m_tdata[34:32] != want.bytes_used)
                    flag_mismatch("bytes_used", 32'(m_tdata[34:32]), 32'(want.bytes_used));
                if (m_tlast != want.buffer_end)
                    flag_mismatch("buffer_end", 32'(m_tlast), 32'(want.buffer_end));
            end
        end
    end

    initial begin
        #5_000_000;
        $display("== FAIL ==");
        $finish;
    end

    initial begin
        logic [31:0]  phase_codes [PHASES];
        stream_byte_t sb;
        int           i, p;
        phase_codes = '{32'h0000_0000, 32'hFFFF_FFFF, $urandom, $urandom, 32'h0000_FFFD};
        repeat (4) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        for (i = 0; i < $size(directed_rows); i++)
            offer_byte(directed_rows[i].value, directed_rows[i].last,
                       directed_rows[i].has_want, directed_rows[i].want);
        s_tvalid <= 1'b0;

        for (p = 0; p < PHASES; p++) begin
            while (chars_due.size() != 0) @(posedge aclk);
            repeat (4) @(posedge aclk);
            calm <= (p == 2);
            if (p == 1) hold_request <= 1'b1;
            write_invalid_code(phase_codes[p]);
            while (byte_plan.size() < PHASE_BYTES) plan_character();
            byte_plan[byte_plan.size() - 1].last = 1'b1;
            while (byte_plan.size() != 0) begin
                sb = byte_plan.pop_front();
                offer_byte(sb.value, sb.last, 1'b0, '0);
            end
            s_tvalid <= 1'b0;
        end

        while (chars_due.size() != 0) @(posedge aclk);
        repeat (8) @(posedge aclk);
        if (errors == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end

endmodule
